// ===== src/lgt_pkg.sv =====
// shared types and constants for the light gate lap timer
package lgt_pkg;

    // timer modes
    typedef enum logic [2:0] {
        MODE_CALIB  = 3'd0,
        MODE_READY  = 3'd1,
        MODE_IGNORE = 3'd2,
        MODE_RUN    = 3'd3,
        MODE_DONE   = 3'd4
    } mode_t;

    // configuration register indexes
    localparam logic [7:0] CFG_DIFF_THRESHOLD = 8'd0;
    localparam logic [7:0] CFG_IGNORE_UNITS   = 8'd1;
    localparam logic [7:0] CFG_IGNORE_UNIT_MS = 8'd2;
    localparam logic [7:0] CFG_DEBOUNCE_MS    = 8'd3;

    // configuration field widths
    localparam int THRESH_W   = 11;
    localparam int UNITS_W    = 8;
    localparam int UNIT_MS_W  = 16;
    localparam int DEBOUNCE_W = 16;
    localparam int WIN_W      = UNITS_W + UNIT_MS_W;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 8;

    // result field widths
    localparam int ELAPSED_W = 32;
    localparam int CDIFF_W   = 11;
    localparam int OUT_W     = 3 + ELAPSED_W + 1 + CDIFF_W + 1;

    // configuration reset values
    localparam logic [THRESH_W-1:0]   THRESH_RST   = 11'd100;
    localparam logic [UNITS_W-1:0]    UNITS_RST    = 8'd1;
    localparam logic [UNIT_MS_W-1:0]  UNIT_MS_RST  = 16'd1000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [WIN_W-1:0]      WIN_RST      = 24'd1000;

endpackage

// ===== src/light_gate_lap_timer.sv =====
// light gate lap timer: tick stream in, one result transfer per tick out
// path: a tick transfer lands in the input register, and its result then moves into the
//   output register, which it enters once that register is free or being drained
// throughput: one tick per cycle, limited only by output back-pressure
// reset: rst_n clears mode to calibration, clock, start time, debounce state
//   and report level, and loads the default configuration; no clearing pass
module light_gate_lap_timer
    import lgt_pkg::*;
#(
    parameter int ADC_BITS  = 10,
    parameter int TIME_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tick input; tdata: sample_lit, sample_dark, button_level, reset_request
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*ADC_BITS+9)/8)*8-1:0]     s_tdata,
    // result output; tdata: reset_event, start_event, finish_event,
    // elapsed_ms, calib_valid, calib_diff, gate_level
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_W-1:0]                    m_tdata,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data
);

    // difference width wide enough for the sample difference and threshold
    localparam int DIFF_W = (ADC_BITS + 1 > THRESH_W) ? ADC_BITS + 1 : THRESH_W;
    // compare width for time differences against the ignore window
    localparam int CMP_W  = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

    // configuration registers
    logic [THRESH_W-1:0]   thresh_reg;
    logic [UNITS_W-1:0]    units_reg;
    logic [UNIT_MS_W-1:0]  unit_ms_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;
    // ignore window, recomputed every cycle from the stable config
    logic [WIN_W-1:0]      win_reg;

    // input register
    logic                  in_valid_reg;
    logic [ADC_BITS-1:0]   lit_reg;
    logic [ADC_BITS-1:0]   dark_reg;
    logic                  btn_reg;
    logic                  req_reg;

    // timer state
    mode_t                 mode_reg, mode_next;
    logic [TIME_BITS-1:0]  now_reg;
    logic [TIME_BITS-1:0]  start_reg, start_next;
    logic                  last_raw_reg;
    logic                  stable_reg, stable_next;
    logic [TIME_BITS-1:0]  last_change_reg, last_change_next;
    logic                  report_reg, report_next;

    // output register
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;

    // step logic
    logic                  advance;
    logic                  btn_changed;
    logic                  settled;
    logic                  rst_hit;
    mode_t                 mode_a;
    logic                  report_a;
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] thresh_x;
    logic                  broken;
    logic [TIME_BITS-1:0]  since_start;
    logic                  window_passed;
    logic                  start_ev;
    logic                  finish_ev;
    logic                  calib_valid;
    logic [CDIFF_W-1:0]    calib_diff;
    logic [TIME_BITS+ELAPSED_W-1:0] elapsed_ext;
    logic [ELAPSED_W-1:0]  elapsed_ms;

    // handshake: the input register moves on whenever the output register is
    // free or being drained in the same cycle
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // configuration writes, values cut to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= THRESH_RST;
            units_reg    <= UNITS_RST;
            unit_ms_reg  <= UNIT_MS_RST;
            debounce_reg <= DEBOUNCE_RST;
            win_reg      <= WIN_RST;
        end
        else
        begin
            win_reg <= WIN_W'(units_reg) * WIN_W'(unit_ms_reg);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_DIFF_THRESHOLD: thresh_reg   <= cfg_data[THRESH_W-1:0];
                    CFG_IGNORE_UNITS:   units_reg    <= cfg_data[UNITS_W-1:0];
                    CFG_IGNORE_UNIT_MS: unit_ms_reg  <= cfg_data[UNIT_MS_W-1:0];
                    CFG_DEBOUNCE_MS:    debounce_reg <= cfg_data[DEBOUNCE_W-1:0];
                    default:            ; // writes past the last register drop
                endcase
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            lit_reg  <= s_tdata[ADC_BITS-1:0];
            dark_reg <= s_tdata[2*ADC_BITS-1:ADC_BITS];
            btn_reg  <= s_tdata[2*ADC_BITS];
            req_reg  <= s_tdata[2*ADC_BITS+1];
        end
    end

    // debounce, host reset and light check
    always_comb
    begin
        // a raw change restarts the debounce time, so it cannot settle now
        btn_changed = btn_reg != last_raw_reg;
        settled     = !btn_changed &&
                      (TIME_BITS'(now_reg - last_change_reg) > TIME_BITS'(debounce_reg));
        stable_next      = settled ? btn_reg : stable_reg;
        last_change_next = btn_changed ? now_reg : last_change_reg;
        // host command and debounced rising button merge into one reset
        rst_hit  = req_reg || (settled && btn_reg && !stable_reg);
        mode_a   = rst_hit ? MODE_READY : mode_reg;
        report_a = rst_hit ? 1'b0 : report_reg;

        diff_x   = DIFF_W'($signed({1'b0, lit_reg})) - DIFF_W'($signed({1'b0, dark_reg}));
        thresh_x = DIFF_W'($signed(thresh_reg));
        broken   = diff_x < thresh_x;

        since_start   = now_reg - start_reg;
        window_passed = CMP_W'(since_start) > CMP_W'(win_reg);
    end

    // next mode
    always_comb
    begin
        mode_next   = mode_a;
        start_next  = start_reg;
        report_next = report_a;
        unique case (mode_a)
            MODE_CALIB: ;
            MODE_READY:
            begin
                if (broken)
                begin
                    mode_next   = MODE_IGNORE;
                    start_next  = now_reg;
                    report_next = 1'b1;
                end
            end
            MODE_IGNORE:
            begin
                // window end and stop break may fall on the same tick
                if (window_passed)
                begin
                    if (broken)
                    begin
                        mode_next   = MODE_DONE;
                        report_next = 1'b0;
                    end
                    else
                        mode_next = MODE_RUN;
                end
            end
            MODE_RUN:
            begin
                if (broken)
                begin
                    mode_next   = MODE_DONE;
                    report_next = 1'b0;
                end
            end
            MODE_DONE: ;
            default:   mode_next = mode_a;
        endcase
    end

    // result fields
    always_comb
    begin
        start_ev    = (mode_a == MODE_READY) && broken;
        finish_ev   = broken && ((mode_a == MODE_RUN) ||
                                 ((mode_a == MODE_IGNORE) && window_passed));
        calib_valid = mode_a == MODE_CALIB;
        calib_diff  = calib_valid ? diff_x[CDIFF_W-1:0] : '0;
        elapsed_ext = (TIME_BITS+ELAPSED_W)'(finish_ev ? since_start : '0);
        elapsed_ms  = elapsed_ext[ELAPSED_W-1:0];
    end

    // timer state, advanced once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_CALIB;
            now_reg         <= '0;
            start_reg       <= '0;
            last_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            last_change_reg <= '0;
            report_reg      <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            now_reg         <= now_reg + 1'b1;
            start_reg       <= start_next;
            last_raw_reg    <= btn_reg;
            stable_reg      <= stable_next;
            last_change_reg <= last_change_next;
            report_reg      <= report_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {report_next, calib_diff, calib_valid, elapsed_ms,
                             finish_ev, start_ev, rst_hit};
    end

endmodule
